### sv/gb5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb5_pkg
// Types and constants shared by the 5x5 Gaussian blur modules.
// ----------------------------------------------------------------------------
package gb5_pkg;

    localparam int KSIZE      = 5;
    localparam int PIX_W      = 8;
    localparam int SLOT_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;

    // Frame height limit, and the widths of the row counters that follow from it.
    localparam int ROW_LIMIT = 1024;
    localparam int HGT_W     = $clog2(ROW_LIMIT + 1);
    localparam int ROW_W     = $clog2(ROW_LIMIT + 4);
    localparam int OROW_W    = $clog2(ROW_LIMIT);

    // Kernel weights, total 159.
    localparam logic [0:4][0:4][3:0] WEIGHTS = '{
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
    };

    // Column sum at most 49 * 255, total plus bias at most 40624.
    localparam int CSUM_W = 14;
    localparam int SUM_W  = 16;
    localparam logic [SUM_W-1:0] ROUND_BIAS = 16'd79;

    // Division by 159 as multiplication by ceil(2^24 / 159), exact below 2^16.
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP = 17'd105518;

    // Five pixels of one image column, or the five row slots of a line store entry.
    typedef logic [0:KSIZE-1][PIX_W-1:0] gb5_col_t;

    // Control that travels with an item from the sequencer into the datapath.
    typedef struct packed {
        logic                          wr;
        logic [SLOT_W-1:0]             wslot;
        logic [PIX_W-1:0]              pixel;
        logic [0:KSIZE-1][SLOT_W-1:0]  rslot;
        logic                          emit;
        logic [1:0]                    ldist;
        logic [1:0]                    rdist;
        logic                          last;
    } gb5_ctrl_t;

endpackage

### sv/gb5_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb5_pix_if / gb5_res_if
// Valid/ready channels for input pixels and blurred results.
// ----------------------------------------------------------------------------
interface gb5_pix_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] pixel;

    modport source (output valid, output func, output pixel, input ready);
    modport sink   (input valid, input func, input pixel, output ready);
endinterface

interface gb5_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] blurred;
    logic       last_of_frame;

    modport source (output valid, output blurred, output last_of_frame, input ready);
    modport sink   (input valid, input blurred, input last_of_frame, output ready);
endinterface

### sv/gb5_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb5_seq
// Frame sequencer: configuration registers, raster counters for input and
// output, and the per-item control for the line store and the kernel.
// ----------------------------------------------------------------------------
module gb5_seq #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gb5_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [gb5_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               take,
    input  logic                               func,
    input  logic [gb5_pkg::PIX_W-1:0]          pixel,
    input  logic                               adv,
    output logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
    output logic                               b_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]       b_addr,
    output gb5_pkg::gb5_ctrl_t                 b_ctrl
);
    import gb5_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [AW-1:0]         in_col_reg,  in_col_next;
    logic [ROW_W-1:0]      in_row_reg,  in_row_next;
    logic [SLOT_W-1:0]     in_slot_reg, in_slot_next;
    logic [AW-1:0]         out_col_reg, out_col_next;
    logic [OROW_W-1:0]     out_row_reg, out_row_next;
    logic                  b_valid_reg;
    logic [AW-1:0]         b_addr_reg;
    gb5_ctrl_t             b_ctrl_reg;

    logic [WW-1:0]    eff_w;
    logic [HGT_W-1:0] eff_h;
    logic             in_frame;
    logic             counted;
    logic             col_end;
    logic             ocol_end;
    logic             orow_end;
    logic [WW-1:0]    rem;
    gb5_ctrl_t        ctrl;

    function automatic logic [SLOT_W-1:0] slot_back(logic [SLOT_W-1:0] s,
                                                    logic [SLOT_W-1:0] age);
        logic [SLOT_W:0] tmp;
        tmp = {1'b0, s} + (SLOT_W + 1)'(KSIZE) - {1'b0, age};
        if (tmp >= (SLOT_W + 1)'(KSIZE))
        begin
            tmp = tmp - (SLOT_W + 1)'(KSIZE);
        end
        return tmp[SLOT_W-1:0];
    endfunction

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (CMPW'(width_reg) > CMPW'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(width_reg);
        end

        if (height_reg == '0)
        begin
            eff_h = HGT_W'(1);
        end
        else if (HGT_W'(height_reg) > HGT_W'(ROW_LIMIT))
        begin
            eff_h = HGT_W'(ROW_LIMIT);
        end
        else
        begin
            eff_h = HGT_W'(height_reg);
        end
    end

    assign in_frame = in_row_reg < ROW_W'(eff_h);
    // A drain item before the last pixel of the frame is dropped unseen.
    assign counted  = !(func && in_frame);
    assign col_end  = WW'(in_col_reg) == eff_w - WW'(1);
    assign ocol_end = WW'(out_col_reg) == eff_w - WW'(1);
    assign orow_end = HGT_W'(out_row_reg) == eff_h - HGT_W'(1);
    assign rem      = eff_w - WW'(1) - WW'(out_col_reg);

    always_comb
    begin
        logic [ROW_W:0]    vr;
        logic [ROW_W:0]    excess;
        logic [SLOT_W-1:0] age;

        ctrl       = '0;
        ctrl.wr    = in_frame;
        ctrl.wslot = in_slot_reg;
        ctrl.pixel = pixel;

        // Output k lags input j by two rows and two pixels.
        ctrl.emit = (in_row_reg >= ROW_W'(4))
                 || (in_row_reg == ROW_W'(3) && eff_w >= WW'(2))
                 || (in_row_reg == ROW_W'(2) && in_col_reg >= AW'(2));
        ctrl.last = ctrl.emit && ocol_end && orow_end;

        ctrl.ldist = (out_col_reg >= AW'(2)) ? 2'd2 : out_col_reg[1:0];
        ctrl.rdist = (rem >= WW'(2)) ? 2'd2 : rem[1:0];

        // The fetched column covers rows in_row-4 .. in_row, clamped to the
        // frame; each row is found by its age against the newest row.
        excess = {1'b0, in_row_reg} + (ROW_W + 1)'(1) - (ROW_W + 1)'(eff_h);
        for (int i = 0; i < KSIZE; i++)
        begin
            vr = {1'b0, in_row_reg} + (ROW_W + 1)'(i);
            if (vr < (ROW_W + 1)'(4))
            begin
                age = in_row_reg[SLOT_W-1:0];
            end
            else if (vr > (ROW_W + 1)'(eff_h) + (ROW_W + 1)'(3))
            begin
                age = excess[SLOT_W-1:0];
            end
            else
            begin
                age = SLOT_W'(4 - i);
            end
            ctrl.rslot[i] = slot_back(in_slot_reg, age);
        end
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_slot_next = in_slot_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (ctrl.last)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            in_slot_next = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else
        begin
            if (col_end)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + ROW_W'(1);
                in_slot_next = (in_slot_reg == SLOT_W'(KSIZE - 1)) ? '0
                             : in_slot_reg + SLOT_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + AW'(1);
            end

            if (ctrl.emit)
            begin
                if (ocol_end)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_slot_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default:          ;
                endcase
                // A register write abandons the frame in progress.
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                in_slot_reg <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else if (take && counted)
            begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                in_slot_reg <= in_slot_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end

            if (adv)
            begin
                b_valid_reg <= take && counted;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_addr_reg <= in_col_reg;
            b_ctrl_reg <= ctrl;
        end
    end

    assign rd_addr = in_col_reg;
    assign b_valid = b_valid_reg;
    assign b_addr  = b_addr_reg;
    assign b_ctrl  = b_ctrl_reg;

endmodule

### sv/gb5_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb5_line_store
// Column-organised line store: each entry holds one column of the five most
// recent rows. Read, insert the new pixel, write back, and pick the column.
// ----------------------------------------------------------------------------
module gb5_line_store #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    input  logic                          b_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]  b_addr,
    input  gb5_pkg::gb5_ctrl_t            b_ctrl,
    output gb5_pkg::gb5_col_t             colvec
);
    import gb5_pkg::*;

    gb5_col_t mem [MAX_WIDTH];
    gb5_col_t rd_reg;
    gb5_col_t fwd_word_reg;
    logic     fwd_reg;

    gb5_col_t base;
    gb5_col_t word;
    logic     wr_en;

    assign wr_en = adv && b_valid && b_ctrl.wr;

    always_comb
    begin
        // A read issued in the same cycle as a write to that entry sees the
        // old contents, so the written word is taken instead.
        base = fwd_reg ? fwd_word_reg : rd_reg;
        word = base;
        if (b_ctrl.wr)
        begin
            word[b_ctrl.wslot] = b_ctrl.pixel;
        end
        for (int i = 0; i < KSIZE; i++)
        begin
            colvec[i] = word[b_ctrl.rslot[i]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[b_addr] <= word;
        end
        if (adv)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fwd_word_reg <= word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (adv)
        begin
            fwd_reg <= wr_en && (rd_addr == b_addr);
        end
    end

endmodule

### sv/gb5_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb5_kernel
// Window of five columns with edge replication, weighted sums, rounding
// division by 159 and the output register.
// ----------------------------------------------------------------------------
module gb5_kernel (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        b_valid,
    input  gb5_pkg::gb5_ctrl_t          b_ctrl,
    input  gb5_pkg::gb5_col_t           colvec,
    input  logic                        out_ready,
    output logic                        adv,
    output logic                        out_valid,
    output logic [gb5_pkg::PIX_W-1:0]   blurred,
    output logic                        last_of_frame
);
    import gb5_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    // Index 0 holds the newest column, two columns right of the centre.
    gb5_col_t          win_reg [KSIZE];
    logic              c_valid_reg;
    logic [1:0]        c_ldist_reg;
    logic [1:0]        c_rdist_reg;
    logic              c_last_reg;
    logic              d_valid_reg;
    logic [CSUM_W-1:0] d_sum_reg [KSIZE];
    logic              d_last_reg;
    logic              e_valid_reg;
    logic [SUM_W-1:0]  e_n_reg;
    logic              e_last_reg;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pix_reg;
    logic              out_last_reg;

    gb5_col_t          tapv [KSIZE];
    logic [CSUM_W-1:0] csum [KSIZE];
    logic [SUM_W-1:0]  total;
    logic [PROD_W-1:0] prod;

    function automatic logic [CSUM_W-1:0] col_sum(gb5_col_t v, int t);
        logic [CSUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < KSIZE; i++)
        begin
            acc = acc + CSUM_W'(WEIGHTS[i][t]) * CSUM_W'(v[i]);
        end
        return acc;
    endfunction

    // The whole pipeline holds only when a finished result waits in the
    // output register and another one stands right behind it.
    assign adv = !(e_valid_reg && out_valid_reg && !out_ready);

    always_comb
    begin
        // Columns beyond the left or right edge repeat the edge column.
        tapv[0] = (c_ldist_reg == 2'd2) ? win_reg[4]
                : (c_ldist_reg == 2'd1) ? win_reg[3] : win_reg[2];
        tapv[1] = (c_ldist_reg != 2'd0) ? win_reg[3] : win_reg[2];
        tapv[2] = win_reg[2];
        tapv[3] = (c_rdist_reg != 2'd0) ? win_reg[1] : win_reg[2];
        tapv[4] = (c_rdist_reg == 2'd2) ? win_reg[0]
                : (c_rdist_reg == 2'd1) ? win_reg[1] : win_reg[2];
        for (int t = 0; t < KSIZE; t++)
        begin
            csum[t] = col_sum(tapv[t], t);
        end
    end

    always_comb
    begin
        total = ROUND_BIAS;
        for (int t = 0; t < KSIZE; t++)
        begin
            total = total + SUM_W'(d_sum_reg[t]);
        end
    end

    assign prod = PROD_W'(e_n_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (b_valid)
            begin
                win_reg[0] <= colvec;
                for (int k = 1; k < KSIZE; k++)
                begin
                    win_reg[k] <= win_reg[k-1];
                end
            end
            c_ldist_reg <= b_ctrl.ldist;
            c_rdist_reg <= b_ctrl.rdist;
            c_last_reg  <= b_ctrl.last;
            for (int t = 0; t < KSIZE; t++)
            begin
                d_sum_reg[t] <= csum[t];
            end
            d_last_reg <= c_last_reg;
            e_n_reg    <= total;
            e_last_reg <= d_last_reg;
        end
        if (adv && e_valid_reg)
        begin
            out_pix_reg  <= prod[RECIP_SHIFT +: PIX_W];
            out_last_reg <= e_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                c_valid_reg <= b_valid && b_ctrl.emit;
                d_valid_reg <= c_valid_reg;
                e_valid_reg <= d_valid_reg;
            end
            if (adv && e_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign blurred       = out_pix_reg;
    assign last_of_frame = out_last_reg;

endmodule

### sv/gaussian_blur_5x5.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_5x5
// Streaming 5x5 Gaussian blur (weights summing to 159) with edge replication.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the pix channel (func = 0), and after the
// last pixel of a frame the host sends 2*width+2 drain items (func = 1).
// Item j of a frame releases the blurred pixel at raster position
// j - (2*width + 2) on the res channel; the final pixel carries last_of_frame.
// Frame width and height are set through cfg_we/cfg_idx/cfg_data while the
// block is idle; a write restarts the frame.
// One item is taken every clock cycle while res does not hold the pipeline.
// The line store is read at the edge of the transfer that releases a result;
// the window, the column sums, the total and the divider multiply are then
// registered in turn, the last into the output register, from which the
// result can leave on res.
// A stall on res holds the pipeline only once the output register and the
// last stage are both full; until then pix keeps taking items.
// Reset clears the counters and sets the sizes to 640 by 480; the line store
// needs no clearing pass, so the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    gb5_pix_if.sink                         pix,
    gb5_res_if.source                       res,
    input  logic                            cfg_we,
    input  logic [gb5_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [gb5_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gb5_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic          adv;
    logic          take;
    logic [AW-1:0] rd_addr;
    logic          b_valid;
    logic [AW-1:0] b_addr;
    gb5_ctrl_t     b_ctrl;
    gb5_col_t      colvec;

    assign pix.ready = adv;
    assign take      = pix.valid && adv;

    gb5_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .take     (take),
        .func     (pix.func),
        .pixel    (pix.pixel),
        .adv      (adv),
        .rd_addr  (rd_addr),
        .b_valid  (b_valid),
        .b_addr   (b_addr),
        .b_ctrl   (b_ctrl)
    );

    gb5_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .rd_addr (rd_addr),
        .b_valid (b_valid),
        .b_addr  (b_addr),
        .b_ctrl  (b_ctrl),
        .colvec  (colvec)
    );

    gb5_kernel u_kernel (
        .clk           (clk),
        .rst_n         (rst_n),
        .b_valid       (b_valid),
        .b_ctrl        (b_ctrl),
        .colvec        (colvec),
        .out_ready     (res.ready),
        .adv           (adv),
        .out_valid     (res.valid),
        .blurred       (res.blurred),
        .last_of_frame (res.last_of_frame)
    );

endmodule
